@@ hdl/dpb_pkg.sv @@
`default_nettype none
package dpb_pkg;

    localparam int DefMaxOrder  = 7;
    localparam int DefMaxRadial = 8;

    localparam logic signed [63:0] FxOne = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] FxMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] FxMin = 64'sh8000_0000_0000_0000;

    // Register indexes on the configuration port.
    localparam logic [0:0] RegMaxOrder   = 1'b0;
    localparam logic [0:0] RegRadialCnt  = 1'b1;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_R2,
        OP_FACDIV,
        OP_F1,
        OP_SQRT,
        OP_ROWINIT,
        OP_ROWSTEP,
        OP_SEEDUP,
        OP_DERIV
    } dpb_op_t;

    // The order field reaches one above the highest emitted order, since the
    // upper row of the top order is built as well.
    typedef struct packed {
        logic    start;
        dpb_op_t op;
        logic [3:0] l;
        logic [3:0] n;
    } dpb_cmd_t;

    typedef struct packed {
        logic done;
    } dpb_sts_t;

    // Saturating add.
    function automatic logic signed [63:0] s_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? FxMin : FxMax;
        return s[63:0];
    endfunction

    // Saturating subtract.
    function automatic logic signed [63:0] s_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? FxMin : FxMax;
        return s[63:0];
    endfunction

    // Magnitude and sign recombination with saturation.
    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic signed [63:0] with_sign(input logic [63:0] m,
                                                     input logic neg,
                                                     input logic ovf);
        if (!neg)
            return (ovf || m[63]) ? FxMax : m;
        if (ovf || (m > 64'h8000_0000_0000_0000))
            return FxMin;
        return 64'd0 - m;
    endfunction

endpackage
`default_nettype wire

@@ hdl/dpb_mul.sv @@
`default_nettype none
// Sequential Q32.32 multiply: four 32x32 partial products, one per cycle,
// then rounding and saturation.
module dpb_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    output logic                    done,
    output logic signed [63:0]      y
);
    import dpb_pkg::*;

    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         busy_reg;
    logic [63:0]  pp;
    logic [127:0] rnd;

    // Partial product chosen by the step counter.
    always_comb
    begin
        case (step_reg[1:0])
            2'd0: pp = ma_reg[31:0]  * mb_reg[31:0];
            2'd1: pp = ma_reg[63:32] * mb_reg[31:0];
            2'd2: pp = ma_reg[31:0]  * mb_reg[63:32];
            default: pp = ma_reg[63:32] * mb_reg[63:32];
        endcase
        rnd = acc_reg + 128'h8000_0000;
    end

    // Accumulate one partial product per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                acc_reg  <= '0;
                ma_reg   <= mag(a);
                mb_reg   <= mag(b);
                neg_reg  <= a[63] ^ b[63];
            end
            else if (busy_reg)
            begin
                if (step_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    y        <= with_sign(rnd[95:32], neg_reg, rnd[127:96] != 32'd0);
                end
                else
                begin
                    case (step_reg[1:0])
                        2'd0: acc_reg <= acc_reg + {64'd0, pp};
                        2'd1, 2'd2: acc_reg <= acc_reg + {32'd0, pp, 32'd0};
                        default: acc_reg <= acc_reg + {pp, 64'd0};
                    endcase
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/dpb_div.sv @@
`default_nettype none
// Restoring divider: Q32.32 quotient, one quotient bit per cycle over
// 128 bits, truncation toward zero, saturation.
module dpb_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    output logic                    done,
    output logic signed [63:0]      y
);
    import dpb_pkg::*;

    logic [127:0] num_reg;
    logic [64:0]  rem_reg;
    logic [63:0]  den_reg;
    logic [63:0]  q_reg;
    logic         qov_reg;
    logic         neg_reg;
    logic         busy_reg;
    logic [6:0]   cnt_reg;
    logic [64:0]  trial;

    assign trial = {rem_reg[63:0], num_reg[127]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= {mag(a), 64'd0} >> 32;
                den_reg  <= mag(b);
                rem_reg  <= '0;
                q_reg    <= '0;
                qov_reg  <= 1'b0;
                neg_reg  <= a[63] ^ b[63];
                if (b == 64'sd0)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    y        <= a[63] ? FxMin : ((a == 64'sd0) ? 64'sd0 : FxMax);
                end
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[126:0], 1'b0};
                qov_reg <= qov_reg | q_reg[63];
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= trial - {1'b0, den_reg};
                    q_reg   <= {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    y        <= with_sign((trial >= {1'b0, den_reg}) ?
                                          {q_reg[62:0], 1'b1} : {q_reg[62:0], 1'b0},
                                          neg_reg, qov_reg | q_reg[63]);
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/dpb_datapath.sv @@
`default_nettype none
// Datapath: shared multiplier and divider, square root, row storage and
// the output register. Each operation runs as a micro-sequence.
module dpb_datapath #(
    parameter int MaxRadial = dpb_pkg::DefMaxRadial
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dpb_pkg::dpb_cmd_t  cmd,
    input  wire logic [31:0]        radius,
    input  wire logic               load_radius,
    output dpb_pkg::dpb_sts_t       sts,
    output logic [63:0]             pot,
    output logic [63:0]             der
);
    import dpb_pkg::*;

    localparam int NW = $clog2(MaxRadial);

    logic signed [63:0] r_reg, r2_reg, fac_reg, f1_reg, seed_reg, rpow_reg;
    logic signed [63:0] upper_reg [MaxRadial];
    logic signed [63:0] cur_reg   [MaxRadial];
    logic signed [63:0] cc_reg, prev_reg, t0_reg, t1_reg;
    logic signed [63:0] ca_reg, cb_reg;

    logic               m_start, m_done, d_start, d_done;
    logic signed [63:0] m_a, m_b, m_y, d_a, d_b, d_y;

    dpb_mul u_mul (.clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
                   .done(m_done), .y(m_y));
    dpb_div u_div (.clk(clk), .rst_n(rst_n), .start(d_start), .a(d_a), .b(d_b),
                   .done(d_done), .y(d_y));

    // Micro-step counter within the active operation.
    logic [3:0]  ph_reg;
    logic        busy_reg;
    dpb_op_t     op_reg;
    logic [3:0]  l_reg;
    logic [3:0]  n_reg;
    logic [5:0]  sq_cnt_reg;
    logic [31:0] sq_res_reg;
    logic [63:0] sq_x_reg;
    logic [63:0] sq_t;
    logic [63:0] sq_sq;
    logic [63:0] twol1;
    logic [NW-1:0] ni, ni1, ni2;

    assign sq_t  = {32'd0, sq_res_reg | (32'h8000_0000 >> sq_cnt_reg[4:0])};
    assign sq_sq = sq_t * sq_t;
    assign ni  = NW'(n_reg - 4'd1);
    assign ni1 = NW'(n_reg - 4'd2);
    assign ni2 = NW'(n_reg - 4'd3);
    // Signed (2l-1) as Q32.32, for the recurrence of order l.
    assign twol1 = {{27{1'b0}}, l_reg, 1'b0, 32'd0} - FxOne;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sts.done <= 1'b0;
            m_start  <= 1'b0;
            d_start  <= 1'b0;
            ph_reg   <= '0;
            op_reg   <= OP_NOP;
        end
        else
        begin
            sts.done <= 1'b0;
            m_start  <= 1'b0;
            d_start  <= 1'b0;
            if (load_radius)
                r_reg <= {24'd0, ((radius == 32'd0) ? 32'd1 : radius), 8'd0};
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                l_reg    <= cmd.l;
                n_reg    <= cmd.n;
                ph_reg   <= '0;
                sq_cnt_reg <= '0;
                sq_res_reg <= '0;
            end
            else if (busy_reg)
            begin
                case (op_reg)
                    OP_R2:
                        if (ph_reg == 4'd0)
                        begin
                            m_a <= r_reg; m_b <= r_reg; m_start <= 1'b1; ph_reg <= 4'd1;
                        end
                        else if (m_done)
                        begin
                            r2_reg <= m_y; busy_reg <= 1'b0; sts.done <= 1'b1;
                        end
                    OP_FACDIV:
                        if (ph_reg == 4'd0)
                        begin
                            d_a <= FxOne; d_b <= s_add(FxOne, r2_reg);
                            d_start <= 1'b1; ph_reg <= 4'd1;
                        end
                        else if (d_done)
                        begin
                            fac_reg <= d_y; busy_reg <= 1'b0; sts.done <= 1'b1;
                        end
                    OP_F1:
                        if (ph_reg == 4'd0)
                        begin
                            m_a <= s_sub(r2_reg, FxOne); m_b <= fac_reg;
                            m_start <= 1'b1; ph_reg <= 4'd1;
                        end
                        else if (m_done)
                        begin
                            f1_reg <= m_y; rpow_reg <= FxOne;
                            busy_reg <= 1'b0; sts.done <= 1'b1;
                        end
                    OP_SQRT:
                        // Floor square root, one result bit per cycle.
                        if (ph_reg == 4'd0)
                        begin
                            sq_x_reg <= {fac_reg[31:0], 32'd0};
                            ph_reg <= 4'd1;
                            if (fac_reg[63] || fac_reg == 64'sd0)
                            begin
                                seed_reg <= 64'sd0; busy_reg <= 1'b0; sts.done <= 1'b1;
                            end
                            else if (fac_reg >= FxOne)
                            begin
                                seed_reg <= FxOne; busy_reg <= 1'b0; sts.done <= 1'b1;
                            end
                        end
                        else
                        begin
                            if (sq_sq <= sq_x_reg)
                                sq_res_reg <= sq_t[31:0];
                            sq_cnt_reg <= sq_cnt_reg + 6'd1;
                            if (sq_cnt_reg == 6'd31)
                            begin
                                seed_reg <= {32'd0, (sq_sq <= sq_x_reg) ? sq_t[31:0]
                                                                        : sq_res_reg};
                                busy_reg <= 1'b0; sts.done <= 1'b1;
                            end
                        end
                    OP_SEEDUP:
                        // seed *= fac*(2l+1); rpow *= r. Here l is the old order.
                        case (ph_reg)
                            4'd0:
                            begin
                                m_a <= fac_reg;
                                m_b <= {{27{1'b0}}, l_reg, 1'b1, 32'd0};
                                m_start <= 1'b1; ph_reg <= 4'd1;
                            end
                            4'd1:
                                if (m_done)
                                begin
                                    m_a <= seed_reg; m_b <= m_y; m_start <= 1'b1;
                                    ph_reg <= 4'd2;
                                end
                            4'd2:
                                if (m_done)
                                begin
                                    seed_reg <= m_y;
                                    m_a <= rpow_reg; m_b <= r_reg; m_start <= 1'b1;
                                    ph_reg <= 4'd3;
                                end
                            default:
                                if (m_done)
                                begin
                                    rpow_reg <= m_y; busy_reg <= 1'b0; sts.done <= 1'b1;
                                end
                        endcase
                    OP_ROWINIT:
                        // c1 = seed, row[0] = c1*rpow into the upper row.
                        if (ph_reg == 4'd0)
                        begin
                            cc_reg <= seed_reg; prev_reg <= 64'sd0;
                            m_a <= seed_reg; m_b <= rpow_reg; m_start <= 1'b1;
                            ph_reg <= 4'd1;
                        end
                        else if (m_done)
                        begin
                            upper_reg[0] <= m_y; busy_reg <= 1'b0; sts.done <= 1'b1;
                        end
                    OP_ROWSTEP:
                        // Step k = n-1: forms c(k+1) and row[k].
                        case (ph_reg)
                            4'd0:
                            begin
                                d_a <= twol1; d_b <= {28'd0, n_reg - 4'd1, 32'd0};
                                d_start <= 1'b1; ph_reg <= 4'd1;
                            end
                            4'd1:
                                if (d_done)
                                begin
                                    // Coefficients 2 + (2l-1)/k and 1 + (2l-1)/k.
                                    ca_reg <= s_add(64'sh2_0000_0000, d_y);
                                    cb_reg <= s_add(FxOne, d_y);
                                    ph_reg <= 4'd2;
                                end
                            4'd2:
                            begin
                                m_a <= ca_reg; m_b <= f1_reg; m_start <= 1'b1;
                                ph_reg <= 4'd3;
                            end
                            4'd3:
                                if (m_done)
                                begin
                                    m_a <= m_y; m_b <= cc_reg; m_start <= 1'b1;
                                    ph_reg <= 4'd4;
                                end
                            4'd4:
                                if (m_done)
                                begin
                                    t0_reg <= m_y;
                                    m_a <= cb_reg; m_b <= prev_reg; m_start <= 1'b1;
                                    ph_reg <= 4'd5;
                                end
                            4'd5:
                                if (m_done)
                                begin
                                    prev_reg <= cc_reg;
                                    cc_reg   <= s_sub(t0_reg, m_y);
                                    m_a <= s_sub(t0_reg, m_y); m_b <= rpow_reg;
                                    m_start <= 1'b1; ph_reg <= 4'd6;
                                end
                            default:
                                if (m_done)
                                begin
                                    upper_reg[NW'(n_reg - 4'd1)] <= m_y;
                                    busy_reg <= 1'b0; sts.done <= 1'b1;
                                end
                        endcase
                    OP_DERIV:
                        // Derivative of current_row entry n-1 against the upper row.
                        case (ph_reg)
                            4'd0:
                            begin
                                m_a <= cur_reg[ni];
                                m_b <= {28'd0, l_reg, 32'd0};
                                m_start <= 1'b1; ph_reg <= 4'd1;
                            end
                            4'd1:
                                if (m_done)
                                begin
                                    d_a <= m_y; d_b <= r_reg; d_start <= 1'b1;
                                    t1_reg <= upper_reg[ni];
                                    ph_reg <= 4'd2;
                                end
                            4'd2:
                            begin
                                if (n_reg >= 4'd2)
                                    t1_reg <= s_sub(t1_reg,
                                                    s_add(upper_reg[ni1], upper_reg[ni1]));
                                ph_reg <= 4'd3;
                            end
                            4'd3:
                            begin
                                if (n_reg >= 4'd3)
                                    t1_reg <= s_add(t1_reg, upper_reg[ni2]);
                                ph_reg <= 4'd4;
                            end
                            default:
                                if (d_done)
                                begin
                                    pot <= cur_reg[ni];
                                    der <= s_sub(d_y, t1_reg);
                                    busy_reg <= 1'b0; sts.done <= 1'b1;
                                end
                        endcase
                    default:
                    begin
                        // Copy the upper row down into the current row.
                        for (int i = 0; i < MaxRadial; i++)
                            cur_reg[i] <= upper_reg[i];
                        busy_reg <= 1'b0; sts.done <= 1'b1;
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/dpb_ctrl.sv @@
`default_nettype none
// Controller: walks the per-radius schedule and hands out result beats.
module dpb_ctrl #(
    parameter int MaxOrder  = dpb_pkg::DefMaxOrder,
    parameter int MaxRadial = dpb_pkg::DefMaxRadial
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        max_order,
    input  wire logic [3:0]        radial_count,
    output logic                   load_radius,
    output dpb_pkg::dpb_cmd_t      cmd,
    input  wire dpb_pkg::dpb_sts_t sts,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             order_index,
    output logic [3:0]             radial_index,
    output logic                   last
);
    import dpb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_R2, S_FAC, S_F1, S_SQRT, S_INIT0, S_STEP0, S_COPY0,
        S_SEED, S_INIT1, S_STEP1, S_DERIV, S_OUT, S_COPY
    } state_t;

    state_t     state_reg;
    logic [2:0] lmax_reg, l_reg;
    logic [3:0] nmax_reg, n_reg;
    logic [3:0] ncl;
    logic [3:0] lup;

    assign ncl = (radial_count == 4'd0) ? 4'd1 :
                 ((radial_count > 4'(MaxRadial)) ? 4'(MaxRadial) : radial_count);
    // Order of the upper row, one above the current order.
    assign lup = {1'b0, l_reg} + 4'd1;
    assign in_stall    = (state_reg != S_IDLE);
    assign load_radius = in_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd       <= '0;
            out_valid <= 1'b0;
            l_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            cmd.start <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        lmax_reg <= (max_order > 3'(MaxOrder)) ? 3'(MaxOrder) : max_order;
                        nmax_reg <= ncl;
                        cmd <= '{start: 1'b1, op: OP_R2, l: 4'd0, n: 4'd0};
                        state_reg <= S_R2;
                    end
                S_R2:
                    if (sts.done)
                    begin
                        cmd <= '{start: 1'b1, op: OP_FACDIV, l: 4'd0, n: 4'd0};
                        state_reg <= S_FAC;
                    end
                S_FAC:
                    if (sts.done)
                    begin
                        cmd <= '{start: 1'b1, op: OP_F1, l: 4'd0, n: 4'd0};
                        state_reg <= S_F1;
                    end
                S_F1:
                    if (sts.done)
                    begin
                        cmd <= '{start: 1'b1, op: OP_SQRT, l: 4'd0, n: 4'd0};
                        state_reg <= S_SQRT;
                    end
                S_SQRT:
                    if (sts.done)
                    begin
                        cmd <= '{start: 1'b1, op: OP_ROWINIT, l: 4'd0, n: 4'd1};
                        state_reg <= S_INIT0;
                    end
                S_INIT0, S_STEP0:
                    if (sts.done)
                    begin
                        if ((state_reg == S_INIT0 ? 4'd1 : n_reg) >= nmax_reg)
                        begin
                            cmd <= '{start: 1'b1, op: OP_NOP, l: 4'd0, n: 4'd0};
                            state_reg <= S_COPY0;
                        end
                        else
                        begin
                            n_reg <= (state_reg == S_INIT0) ? 4'd2 : n_reg + 4'd1;
                            cmd <= '{start: 1'b1, op: OP_ROWSTEP, l: 4'd0,
                                     n: (state_reg == S_INIT0) ? 4'd2 : n_reg + 4'd1};
                            state_reg <= S_STEP0;
                        end
                    end
                S_COPY0:
                    if (sts.done)
                    begin
                        l_reg <= 3'd0;
                        cmd <= '{start: 1'b1, op: OP_SEEDUP, l: 4'd0, n: 4'd0};
                        state_reg <= S_SEED;
                    end
                S_SEED:
                    if (sts.done)
                    begin
                        cmd <= '{start: 1'b1, op: OP_ROWINIT, l: lup, n: 4'd1};
                        state_reg <= S_INIT1;
                    end
                S_INIT1, S_STEP1:
                    if (sts.done)
                    begin
                        if ((state_reg == S_INIT1 ? 4'd1 : n_reg) >= nmax_reg)
                        begin
                            n_reg <= 4'd1;
                            cmd <= '{start: 1'b1, op: OP_DERIV, l: {1'b0, l_reg}, n: 4'd1};
                            state_reg <= S_DERIV;
                        end
                        else
                        begin
                            n_reg <= (state_reg == S_INIT1) ? 4'd2 : n_reg + 4'd1;
                            cmd <= '{start: 1'b1, op: OP_ROWSTEP, l: lup,
                                     n: (state_reg == S_INIT1) ? 4'd2 : n_reg + 4'd1};
                            state_reg <= S_STEP1;
                        end
                    end
                S_DERIV:
                    if (sts.done)
                    begin
                        out_valid    <= 1'b1;
                        order_index  <= l_reg;
                        radial_index <= n_reg;
                        last         <= (l_reg == lmax_reg) && (n_reg == nmax_reg);
                        state_reg    <= S_OUT;
                    end
                S_OUT:
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        if (n_reg < nmax_reg)
                        begin
                            n_reg <= n_reg + 4'd1;
                            cmd <= '{start: 1'b1, op: OP_DERIV, l: {1'b0, l_reg},
                                     n: n_reg + 4'd1};
                            state_reg <= S_DERIV;
                        end
                        else if (l_reg == lmax_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            cmd <= '{start: 1'b1, op: OP_NOP, l: 4'd0, n: 4'd0};
                            state_reg <= S_COPY;
                        end
                    end
                S_COPY:
                    if (sts.done)
                    begin
                        l_reg <= l_reg + 3'd1;
                        cmd <= '{start: 1'b1, op: OP_SEEDUP, l: lup, n: 4'd0};
                        state_reg <= S_SEED;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/disk_potential_basis_with_derivative.sv @@
`default_nettype none
// Flat-disk potential basis with radial derivative.
// Input channel: radius (unsigned Q8.24) with in_valid/in_stall; a beat is
// taken when in_valid is high and in_stall low. One radius at a time.
// Output channel: one beat per (order, radial index), order-major, with
// potential and derivative in signed Q32.32; last marks the final beat.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 max_order,
// 1 radial_count) and cfg_data; write only while idle.
// Resources: one shared multiplier and one bit-serial divider. A radius
// needs a setup sequence, then (max_order+2) rows of (radial_count-1)
// recurrence steps, a seed update and row start per order, and one
// derivative step per result beat, plus receiver stalls.
// in_stall stays high from the accepted radius until its last beat is taken.
// Reset clears the controller; the block then takes a new radius.
// When the receiver stalls, the result beat holds and work pauses.
module disk_potential_basis_with_derivative #(
    parameter int MaxOrder  = dpb_pkg::DefMaxOrder,
    parameter int MaxRadial = dpb_pkg::DefMaxRadial
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] radius,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       order_index,
    output logic [3:0]       radial_index,
    output logic signed [63:0] potential,
    output logic signed [63:0] derivative,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import dpb_pkg::*;

    logic [2:0] max_order_reg;
    logic [3:0] radial_count_reg;
    dpb_cmd_t   cmd;
    dpb_sts_t   sts;
    logic       load_radius;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_order_reg    <= 3'd4;
            radial_count_reg <= 4'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                RegMaxOrder:  max_order_reg    <= cfg_data[2:0];
                RegRadialCnt: radial_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    dpb_ctrl #(.MaxOrder(MaxOrder), .MaxRadial(MaxRadial)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .max_order(max_order_reg), .radial_count(radial_count_reg),
        .load_radius(load_radius), .cmd(cmd), .sts(sts),
        .out_valid(out_valid), .out_stall(out_stall),
        .order_index(order_index), .radial_index(radial_index), .last(last)
    );

    dpb_datapath #(.MaxRadial(MaxRadial)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .radius(radius),
        .load_radius(load_radius), .sts(sts), .pot(potential), .der(derivative)
    );
endmodule
`default_nettype wire

@@ verif/tb_disk_potential_basis_with_derivative.sv @@
`timescale 1ns / 1ps

module tb_disk_potential_basis_with_derivative;
    import dpb_pkg::*;

    localparam longint QOne = 64'sh0000_0001_0000_0000;
    localparam longint QMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint QMin = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [2:0]  order;
        logic [3:0]  radial;
        longint      pot;
        longint      deriv;
        logic        fin;
    } basis_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] radius;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  order_index;
    logic [3:0]  radial_index;
    logic signed [63:0] potential;
    logic signed [63:0] derivative;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    // Configuration as the block should currently hold it.
    logic [2:0] order_setting;
    logic [3:0] count_setting;

    logic [31:0] radius_backlog[$];
    basis_beat_t basis_expected[$];
    int          mismatches;
    int          send_wait;
    int          recv_wait;
    logic        steady;
    logic        long_hold;

    disk_potential_basis_with_derivative DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .radius(radius),
        .out_valid(out_valid), .out_stall(out_stall),
        .order_index(order_index), .radial_index(radial_index),
        .potential(potential), .derivative(derivative), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Fixed-point helpers, signed Q32.32 with saturation.
    function automatic longint q_sign(input logic [63:0] m, input logic neg,
                                      input logic ovf);
        if (!neg)
            return (ovf || m[63]) ? QMax : longint'(m);
        if (ovf || m >= 64'h8000_0000_0000_0000)
            return QMin;
        return longint'(64'd0 - m);
    endfunction

    function automatic logic [63:0] q_abs(input longint a);
        return (a < 0) ? 64'd0 - 64'(a) : 64'(a);
    endfunction

    function automatic longint q_add(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            return s[64] ? QMin : QMax;
        return longint'(s[63:0]);
    endfunction

    function automatic longint q_sub(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63])
            return s[64] ? QMin : QMax;
        return longint'(s[63:0]);
    endfunction

    // Product rounded to nearest, ties away from zero.
    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, q_abs(a)} * {64'd0, q_abs(b)};
        p = p + 128'h8000_0000;
        return q_sign(p[95:32], (a < 0) != (b < 0), p[127:96] != 0);
    endfunction

    // Quotient truncated toward zero.
    function automatic longint q_div(input longint a, input longint b);
        logic [127:0] q;
        if (b == 0)
            return (a > 0) ? QMax : ((a < 0) ? QMin : 0);
        q = {32'd0, q_abs(a), 32'd0} / {64'd0, q_abs(b)};
        return q_sign(q[63:0], (a < 0) != (b < 0), q[127:64] != 0);
    endfunction

    function automatic longint q_sqrt(input longint f);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] t;
        if (f <= 0)
            return 0;
        if (f >= QOne)
            return QOne;
        x = 64'(f) << 32;
        res = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = res | (64'd1 << b);
            if (t * t <= x)
                res = t;
        end
        return longint'(res);
    endfunction

    // One potential row of order l via the three-term recurrence in n.
    function automatic void basis_row(output longint row[8], input int l, input int n,
                                      input longint f1, input longint seed,
                                      input longint rpow);
        longint cur;
        longint prev;
        longint prev2;
        longint q;
        longint ca;
        longint cb;
        cur = seed;
        prev = 0;
        foreach (row[i])
            row[i] = 0;
        row[0] = q_mul(cur, rpow);
        for (int k = 1; k < n; k++)
        begin
            q = (longint'(2 * l - 1) * QOne) / longint'(k);
            ca = q_add(2 * QOne, q);
            cb = q_add(QOne, q);
            prev2 = prev;
            prev = cur;
            cur = q_sub(q_mul(q_mul(ca, f1), prev), q_mul(cb, prev2));
            row[k] = q_mul(cur, rpow);
        end
    endfunction

    // Queue every basis value and derivative that one radius produces.
    task automatic predict_basis(input logic [31:0] rad);
        logic [31:0] rin;
        longint r;
        longint r2;
        longint fac;
        longint f1;
        longint seed;
        longint rpow;
        longint low_row[8];
        longint high_row[8];
        longint term;
        longint up;
        int lmax;
        int nmax;
        basis_beat_t b;
        rin = (rad == 0) ? 32'd1 : rad;
        r = longint'({24'd0, rin, 8'd0});
        lmax = order_setting;
        nmax = (count_setting == 0) ? 1 : ((count_setting > 8) ? 8 : count_setting);
        r2 = q_mul(r, r);
        fac = q_div(QOne, q_add(QOne, r2));
        f1 = q_mul(q_sub(r2, QOne), fac);
        seed = q_sqrt(fac);
        rpow = QOne;
        basis_row(low_row, 0, nmax, f1, seed, rpow);
        for (int l = 0; l <= lmax; l++)
        begin
            seed = q_mul(seed, q_mul(fac, longint'(2 * l + 1) * QOne));
            rpow = q_mul(rpow, r);
            basis_row(high_row, l + 1, nmax, f1, seed, rpow);
            for (int n = 0; n < nmax; n++)
            begin
                term = q_div(q_mul(low_row[n], longint'(l) * QOne), r);
                up = high_row[n];
                if (n >= 1)
                    up = q_sub(up, q_add(high_row[n - 1], high_row[n - 1]));
                if (n >= 2)
                    up = q_add(up, high_row[n - 2]);
                b.order = 3'(l);
                b.radial = 4'(n + 1);
                b.pot = low_row[n];
                b.deriv = q_sub(term, up);
                b.fin = (l == lmax) && (n == nmax - 1);
                basis_expected.push_back(b);
            end
            low_row = high_row;
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Input driver: offers backlog radii, with a random gap after each beat outside steady phases.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            radius <= 32'd0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_basis(radius);
                send_wait = steady ? 0 : $urandom_range(0, 8);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (radius_backlog.size() > 0)
                begin
                    radius <= radius_backlog.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted beat and draws the next stall.
    always @(posedge clk or negedge rst_n)
    begin
        basis_beat_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (basis_expected.size() == 0)
                begin
                    flag_mismatch("result beat with nothing expected");
                end
                else
                begin
                    e = basis_expected.pop_front();
                    if (order_index !== e.order)
                        flag_mismatch($sformatf("order %0d, want %0d", order_index, e.order));
                    if (radial_index !== e.radial)
                        flag_mismatch($sformatf("radial %0d, want %0d",
                                                radial_index, e.radial));
                    if (potential !== e.pot)
                        flag_mismatch($sformatf("potential %h, want %h", potential, e.pot));
                    if (derivative !== e.deriv)
                        flag_mismatch($sformatf("derivative %h, want %h",
                                                derivative, e.deriv));
                    if (last !== e.fin)
                        flag_mismatch($sformatf("last %b, want %b", last, e.fin));
                end
                recv_wait = steady ? 0 : $urandom_range(0, 8);
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
            end
            out_stall <= long_hold || (recv_wait > 0);
        end
    end

    // Write one register over the configuration port, then mirror it.
    task automatic write_setting(input logic idx, input logic [31:0] val);
        logic [31:0] word;
        word = {16'($urandom_range(0, 32'hFFFF)), val[15:0]};
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= word;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == RegMaxOrder)
            order_setting = word[2:0];
        else
            count_setting = word[3:0];
    endtask

    task automatic drain_block();
        while (radius_backlog.size() > 0 || in_valid || basis_expected.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Half mid-range radii from 1/16 to 4.0, a quarter tiny and a quarter fully random.
    function automatic logic [31:0] pick_radius();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(1, 32'h0000_FFFF);
            default: return $urandom_range(32'h0010_0000, 32'h0400_0000);
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 32'd0;
        steady = 1'b0;
        long_hold = 1'b0;
        mismatches = 0;
        order_setting = 3'd4;
        count_setting = 4'd8;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: zero radius, extremes and radius exactly one.
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0100_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h00FF_FFFF, 32'h0000_0100};
        foreach (directed[i])
            radius_backlog.push_back(directed[i]);
        drain_block();

        // Largest order and count.
        write_setting(RegMaxOrder, 32'd7);
        write_setting(RegRadialCnt, 32'd8);
        radius_backlog.push_back(32'h0080_0000);
        radius_backlog.push_back(32'hFFFF_FFFF);
        drain_block();

        // Smallest order with a zero count, an oversized count and a count of one.
        write_setting(RegMaxOrder, 32'd0);
        write_setting(RegRadialCnt, 32'd0);
        radius_backlog.push_back(32'h0100_0000);
        radius_backlog.push_back(32'd0);
        radius_backlog.push_back(32'hFFFF_FFFF);
        drain_block();
        write_setting(RegRadialCnt, 32'd15);
        radius_backlog.push_back(32'h0200_0000);
        radius_backlog.push_back(32'h0000_0001);
        drain_block();
        write_setting(RegRadialCnt, 32'd1);
        radius_backlog.push_back(32'h0300_0000);
        drain_block();

        // Random phases, mostly small settings to keep the run short.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_setting(RegMaxOrder, (ph == 7) ? 32'd7 : $urandom_range(0, 2));
            write_setting(RegRadialCnt,
                          (ph == 7) ? 32'd8 : ((ph == 4) ? $urandom_range(9, 15)
                                                          : $urandom_range(0, 3)));
            steady <= (ph % 3 == 1);
            if (ph == 2)
            begin
                fork
                    begin
                        long_hold <= 1'b1;
                        repeat (3000) @(posedge clk);
                        long_hold <= 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < ((ph == 7) ? 4 : 25); i++)
                radius_backlog.push_back(pick_radius());
            drain_block();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && basis_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/dpb_pkg.sv
hdl/dpb_mul.sv
hdl/dpb_div.sv
hdl/dpb_datapath.sv
hdl/dpb_ctrl.sv
hdl/disk_potential_basis_with_derivative.sv
verif/tb_disk_potential_basis_with_derivative.sv
